// File: sv/hsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types and constants for the health sensor frame deframer.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    // Frame layout
    localparam logic [7:0] HEADER_BYTE    = 8'hFF;
    localparam int         BODY_ABSENT_BIT = 2;
    localparam logic [7:0] POS_HUNT       = 8'd0;
    localparam logic [7:0] POS_TYPE       = 8'd1;
    localparam logic [7:0] POS_SEQ_LO     = 8'd2;
    localparam logic [7:0] POS_SEQ_HI     = 8'd3;
    localparam logic [7:0] POS_HEART      = 8'd65;
    localparam logic [7:0] POS_SPO2       = 8'd66;
    localparam logic [7:0] POS_MICRO      = 8'd67;
    localparam logic [7:0] POS_FATIGUE    = 8'd68;
    localparam logic [7:0] POS_SYSTOLIC   = 8'd71;
    localparam logic [7:0] POS_DIASTOLIC  = 8'd72;

    // Input function codes
    localparam logic FUNC_BYTE    = 1'b0;
    localparam logic FUNC_TIMEOUT = 1'b1;

    // Result kind codes
    localparam logic [1:0] KIND_REALTIME = 2'd0;
    localparam logic [1:0] KIND_TEST     = 2'd1;
    localparam logic [1:0] KIND_DROPPED  = 2'd2;
    localparam logic [1:0] KIND_ABANDON  = 2'd3;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  heart_rate;
        logic [7:0]  spo2;
        logic [7:0]  microcirculation;
        logic [7:0]  fatigue_level;
        logic [7:0]  systolic;
        logic [7:0]  diastolic;
        logic        body_detected;
        logic [15:0] test_sequence;
    } t_out_item;

endpackage

// File: sv/hsfd_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_framer
// Frame position tracking, field capture and result generation, one byte
// per cycle while i_accept is high.
// ----------------------------------------------------------------------------
module hsfd_framer #(
    parameter int RT_LEN   = 88,
    parameter int TEST_LEN = 196
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  hsfd_pkg::t_in_item  i_item,
    output logic                o_has_result,
    output hsfd_pkg::t_out_item o_result
);

    localparam logic [7:0] RT_LAST   = 8'(RT_LEN - 1);
    localparam logic [7:0] TEST_LAST = 8'(TEST_LEN - 1);

    logic [7:0]  r_pos, n_pos;
    logic        r_is_test, n_is_test;
    logic [7:0]  r_heart, n_heart;
    logic [7:0]  r_spo2, n_spo2;
    logic [7:0]  r_micro, n_micro;
    logic [7:0]  r_fatigue, n_fatigue;
    logic [7:0]  r_systolic, n_systolic;
    logic [7:0]  r_diastolic, n_diastolic;
    logic [15:0] r_seq, n_seq;

    logic       is_test_now;
    logic [7:0] b;

    assign b = i_item.rx_byte;

    // Frame type is decided by the second byte, used in that same cycle
    assign is_test_now = (r_pos == hsfd_pkg::POS_TYPE) ? (b == hsfd_pkg::HEADER_BYTE)
                                                       : r_is_test;

    // Next state and result
    always_comb begin
        n_pos        = r_pos;
        n_is_test    = r_is_test;
        n_heart      = r_heart;
        n_spo2       = r_spo2;
        n_micro      = r_micro;
        n_fatigue    = r_fatigue;
        n_systolic   = r_systolic;
        n_diastolic  = r_diastolic;
        n_seq        = r_seq;
        o_has_result = 1'b0;
        o_result     = '0;

        if (i_item.func == hsfd_pkg::FUNC_TIMEOUT) begin
            // timeout abandons a partial frame, ignored while hunting
            if (r_pos != hsfd_pkg::POS_HUNT) begin
                n_pos         = hsfd_pkg::POS_HUNT;
                o_has_result  = 1'b1;
                o_result.kind = hsfd_pkg::KIND_ABANDON;
            end
        end else if (r_pos == hsfd_pkg::POS_HUNT) begin
            if (b != hsfd_pkg::HEADER_BYTE) begin
                o_has_result  = 1'b1;
                o_result.kind = hsfd_pkg::KIND_DROPPED;
            end else begin
                n_pos = hsfd_pkg::POS_TYPE;
            end
        end else begin
            n_is_test = is_test_now;
            n_pos     = r_pos + 8'd1;
            if (is_test_now) begin
                if (r_pos == hsfd_pkg::POS_SEQ_LO) begin
                    n_seq = {r_seq[15:8], b};
                end else if (r_pos == hsfd_pkg::POS_SEQ_HI) begin
                    n_seq = {b, r_seq[7:0]};
                end
                if (r_pos >= hsfd_pkg::POS_SEQ_LO && r_pos >= TEST_LAST) begin
                    n_pos                  = hsfd_pkg::POS_HUNT;
                    o_has_result           = 1'b1;
                    o_result.kind          = hsfd_pkg::KIND_TEST;
                    o_result.test_sequence = n_seq;
                end
            end else begin
                case (r_pos)
                    hsfd_pkg::POS_HEART:     n_heart     = b;
                    hsfd_pkg::POS_SPO2:      n_spo2      = b;
                    hsfd_pkg::POS_MICRO:     n_micro     = b;
                    hsfd_pkg::POS_FATIGUE:   n_fatigue   = b;
                    hsfd_pkg::POS_SYSTOLIC:  n_systolic  = b;
                    hsfd_pkg::POS_DIASTOLIC: n_diastolic = b;
                    default: ;
                endcase
                if (r_pos >= RT_LAST) begin
                    n_pos                     = hsfd_pkg::POS_HUNT;
                    o_has_result              = 1'b1;
                    o_result.kind             = hsfd_pkg::KIND_REALTIME;
                    o_result.heart_rate       = r_heart;
                    o_result.spo2             = r_spo2;
                    o_result.microcirculation = r_micro;
                    o_result.fatigue_level    = r_fatigue;
                    o_result.systolic         = r_systolic;
                    o_result.diastolic        = r_diastolic;
                    o_result.body_detected    = ~b[hsfd_pkg::BODY_ABSENT_BIT];
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= hsfd_pkg::POS_HUNT;
            r_is_test   <= 1'b0;
            r_heart     <= '0;
            r_spo2      <= '0;
            r_micro     <= '0;
            r_fatigue   <= '0;
            r_systolic  <= '0;
            r_diastolic <= '0;
            r_seq       <= '0;
        end else if (i_accept) begin
            r_pos       <= n_pos;
            r_is_test   <= n_is_test;
            r_heart     <= n_heart;
            r_spo2      <= n_spo2;
            r_micro     <= n_micro;
            r_fatigue   <= n_fatigue;
            r_systolic  <= n_systolic;
            r_diastolic <= n_diastolic;
            r_seq       <= n_seq;
        end
    end

endmodule

// File: sv/hsfd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_out_buf
// Two-entry output register with skid stage; ready toward the framer is
// registered and depends only on the skid entry.
// ----------------------------------------------------------------------------
module hsfd_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hsfd_pkg::t_out_item i_item,
    output logic                o_can_take,
    output logic                o_valid,
    input  logic                i_ready,
    output hsfd_pkg::t_out_item o_item
);

    logic                r_main_valid;
    logic                r_skid_valid;
    hsfd_pkg::t_out_item r_main;
    hsfd_pkg::t_out_item r_skid;
    logic                pop;

    assign pop        = r_main_valid && i_ready;
    assign o_valid    = r_main_valid;
    assign o_item     = r_main;
    assign o_can_take = !r_skid_valid;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end
            r_main_valid <= 1'b1;
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid <= i_item;
            end else begin
                r_main <= i_item;
            end
        end
    end

endmodule

// File: sv/health_sensor_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// health_sensor_frame_deframer
// Frames health sensor UART bytes and reports realtime vital values, test
// frame sequence numbers, dropped bytes and abandoned frames.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------
//  input   | in        | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  result  | out       | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
//  One byte or timeout tick is accepted per cycle while o_in_ready is high;
//  its result, if any, is registered into the output buffer.
//  A two-entry output buffer lets input continue while one result waits;
//  o_in_ready drops only when both entries are full.
//  Synchronous active-low reset returns the framer to header hunting and
//  empties the output buffer.
// ----------------------------------------------------------------------------
module health_sensor_frame_deframer #(
    parameter int RT_LEN   = 88,
    parameter int TEST_LEN = 196
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hsfd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hsfd_pkg::t_out_item o_out_data
);

    logic                accept;
    logic                has_result;
    hsfd_pkg::t_out_item result;

    assign accept = i_in_valid && o_in_ready;

    // Framing logic
    hsfd_framer #(
        .RT_LEN   (RT_LEN),
        .TEST_LEN (TEST_LEN)
    ) u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (i_in_data),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // Result buffer
    hsfd_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept && has_result),
        .i_item     (result),
        .o_can_take (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_data)
    );

endmodule

// File: sv/hsfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_checker
// Port-level checks on the deframer's handshakes and output buffering.
// ----------------------------------------------------------------------------
module hsfd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input hsfd_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input hsfd_pkg::t_out_item o_out_data
);

    // Reset empties the buffer and opens the input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("buffer not empty after reset");

    // Input stalls only when a result is pending
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // A full buffer stays full while the output is stalled
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_ready && !i_out_ready) |=> !o_in_ready)
        else $error("input reopened while output stalled");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind health_sensor_frame_deframer hsfd_checker u_hsfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: bench/tb_health_sensor_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_health_sensor_frame_deframer
// Self-checking bench for the health sensor frame deframer. Byte and timeout
// requests go in over a valid/ready channel. A scoreboard tracks the framing
// state and predicts each result, and the bench checks every result field by
// field. Directed frames cover the value extremes and the special cases.
// Random realtime and test frames follow, mixed with noise and cut frames,
// under three sender/receiver stall profiles.
// ----------------------------------------------------------------------------
module tb_health_sensor_frame_deframer;

    localparam int FRAME_RT_LEN   = 88;
    localparam int FRAME_TEST_LEN = 196;
    localparam int TOTAL_ITEMS    = 850;
    localparam int CYCLE_LIMIT    = 200000;

    // Body fill patterns for generated frames
    localparam int FILL_ZERO   = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_RANDOM = 2;

    // ------------------------------------------------------------------------
    // Scoreboard: framing state, expected results, per-kind tallies
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        hsfd_pkg::t_out_item expected_q[$];
        logic [7:0]  position;
        bit          in_test_frame;
        logic [7:0]  heart, spo2, micro, fatigue, systolic, diastolic;
        logic [15:0] seq_value;
        int          mismatches;
        int          results_checked;
        int          kind_count[4];

        function new();
            position      = hsfd_pkg::POS_HUNT;
            in_test_frame = 1'b0;
            heart         = '0;
            spo2          = '0;
            micro         = '0;
            fatigue       = '0;
            systolic      = '0;
            diastolic     = '0;
            seq_value     = '0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        // Advance the framing state for one accepted request
        function void note_request(hsfd_pkg::t_in_item req);
            hsfd_pkg::t_out_item res;
            bit         emit;
            logic [7:0] pos;
            logic [7:0] b;
            res  = '0;
            emit = 1'b0;
            pos  = position;
            b    = req.rx_byte;
            if (req.func == hsfd_pkg::FUNC_TIMEOUT) begin
                // timeout drops a partial frame; ignored while hunting
                if (pos != hsfd_pkg::POS_HUNT) begin
                    position = hsfd_pkg::POS_HUNT;
                    res.kind = hsfd_pkg::KIND_ABANDON;
                    emit     = 1'b1;
                end
            end else if (pos == hsfd_pkg::POS_HUNT) begin
                if (b != hsfd_pkg::HEADER_BYTE) begin
                    res.kind = hsfd_pkg::KIND_DROPPED;
                    emit     = 1'b1;
                end else begin
                    position = hsfd_pkg::POS_TYPE;
                end
            end else begin
                if (pos == hsfd_pkg::POS_TYPE) in_test_frame = (b == hsfd_pkg::HEADER_BYTE);
                position = pos + 8'd1;
                if (in_test_frame) begin
                    if (pos == hsfd_pkg::POS_SEQ_LO) seq_value[7:0] = b;
                    else if (pos == hsfd_pkg::POS_SEQ_HI) seq_value[15:8] = b;
                    if (pos >= hsfd_pkg::POS_SEQ_LO && pos >= 8'(FRAME_TEST_LEN - 1)) begin
                        position          = hsfd_pkg::POS_HUNT;
                        res.kind          = hsfd_pkg::KIND_TEST;
                        res.test_sequence = seq_value;
                        emit              = 1'b1;
                    end
                end else begin
                    case (pos)
                        hsfd_pkg::POS_HEART:     heart     = b;
                        hsfd_pkg::POS_SPO2:      spo2      = b;
                        hsfd_pkg::POS_MICRO:     micro     = b;
                        hsfd_pkg::POS_FATIGUE:   fatigue   = b;
                        hsfd_pkg::POS_SYSTOLIC:  systolic  = b;
                        hsfd_pkg::POS_DIASTOLIC: diastolic = b;
                        default: ;
                    endcase
                    if (pos >= 8'(FRAME_RT_LEN - 1)) begin
                        position             = hsfd_pkg::POS_HUNT;
                        res.kind             = hsfd_pkg::KIND_REALTIME;
                        res.heart_rate       = heart;
                        res.spo2             = spo2;
                        res.microcirculation = micro;
                        res.fatigue_level    = fatigue;
                        res.systolic         = systolic;
                        res.diastolic        = diastolic;
                        res.body_detected    = ~b[hsfd_pkg::BODY_ABSENT_BIT];
                        emit                 = 1'b1;
                    end
                end
            end
            if (emit) begin
                expected_q.push_back(res);
                kind_count[res.kind]++;
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 50) $display("MISMATCH: %s", msg);
        endtask

        task check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
            if (got_v !== want_v)
                report_mismatch($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                    results_checked, name, want_v, got_v));
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(hsfd_pkg::t_out_item got);
            hsfd_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, kind %0d",
                    got.kind));
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            check_field("kind", 16'(want.kind), 16'(got.kind));
            check_field("heart_rate", 16'(want.heart_rate), 16'(got.heart_rate));
            check_field("spo2", 16'(want.spo2), 16'(got.spo2));
            check_field("microcirculation", 16'(want.microcirculation),
                16'(got.microcirculation));
            check_field("fatigue_level", 16'(want.fatigue_level), 16'(got.fatigue_level));
            check_field("systolic", 16'(want.systolic), 16'(got.systolic));
            check_field("diastolic", 16'(want.diastolic), 16'(got.diastolic));
            check_field("body_detected", 16'(want.body_detected), 16'(got.body_detected));
            check_field("test_sequence", want.test_sequence, got.test_sequence);
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    hsfd_pkg::t_in_item  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    hsfd_pkg::t_out_item out_data;

    frame_scoreboard sb = new();
    int send_idle_pct = 22;
    int recv_idle_pct = 55;
    int requests_sent = 0;
    int cycle_count = 0;

    health_sensor_frame_deframer #(
        .RT_LEN  (FRAME_RT_LEN),
        .TEST_LEN(FRAME_TEST_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                cycle_count, sb.expected_q.size());
            $display("health_sensor_frame_deframer regression: fail");
            $finish;
        end
    end

    // Result side: check on handshake, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) sb.check_result(out_data);
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Present one request, holding it until accepted
    task automatic send_request(hsfd_pkg::t_in_item req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sb.note_request(req);
        requests_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        hsfd_pkg::t_in_item req;
        req.func    = hsfd_pkg::FUNC_BYTE;
        req.rx_byte = b;
        send_request(req);
    endtask

    // rx_byte is don't-care on a timeout; randomize it anyway
    task automatic send_timeout();
        hsfd_pkg::t_in_item req;
        req.func    = hsfd_pkg::FUNC_TIMEOUT;
        req.rx_byte = 8'($urandom_range(0, 255));
        send_request(req);
    endtask

    // Send a frame; if cut_at is below the frame length, stop there and time out
    task automatic send_frame(bit test_frame, int fill, int cut_at);
        int         len;
        int         p;
        logic [7:0] b;
        len = test_frame ? FRAME_TEST_LEN : FRAME_RT_LEN;
        for (p = 0; p < len && p < cut_at; p++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = ($urandom_range(0, 7) == 0) ? hsfd_pkg::HEADER_BYTE
                                                           : 8'($urandom_range(0, 255));
            endcase
            if (p == 0) b = hsfd_pkg::HEADER_BYTE;
            else if (p == 1) b = test_frame ? hsfd_pkg::HEADER_BYTE
                                            : ((b == hsfd_pkg::HEADER_BYTE) ? 8'hFE : b);
            send_byte(b);
        end
        if (cut_at < len) send_timeout();
    endtask

    // One random sequence: mostly well-formed frames, some noise and cut frames
    task automatic send_random_sequence();
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            send_frame(1'b0, FILL_RANDOM, FRAME_RT_LEN);
        end else if (roll < 55) begin
            send_frame(1'b1, FILL_RANDOM, FRAME_TEST_LEN);
        end else if (roll < 70) begin
            if ($urandom_range(0, 1) == 0)
                send_frame(1'b0, FILL_RANDOM, $urandom_range(1, FRAME_RT_LEN - 1));
            else
                send_frame(1'b1, FILL_RANDOM, $urandom_range(1, 8));
        end else if (roll < 92) begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            // stray header may have opened a frame; usually clear it
            if ($urandom_range(0, 3) != 0) send_timeout();
        end else begin
            send_timeout();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: hunting, value extremes, timeouts at frame edges
        send_timeout();
        send_byte(8'h00);
        send_byte(8'hFE);
        send_frame(1'b0, FILL_ONES, FRAME_RT_LEN);
        send_frame(1'b0, FILL_ZERO, FRAME_RT_LEN);
        send_frame(1'b1, FILL_ONES, FRAME_TEST_LEN);
        send_frame(1'b0, FILL_RANDOM, 1);
        send_frame(1'b1, FILL_RANDOM, 2);
        send_frame(1'b1, FILL_RANDOM, 4);
        send_timeout();

        // Random, three stall profiles sharing the remaining request budget
        for (int ph = 0; ph < 3; ph++) begin
            int stop_at;
            send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 55 : 0;
            recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 22 : 0;
            stop_at = requests_sent + (TOTAL_ITEMS - requests_sent) / (3 - ph);
            while (requests_sent < stop_at)
                send_random_sequence();
        end
        in_valid <= 1'b0;

        // Drain, then give the output buffer time to show anything extra
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked in %0d cycles",
            requests_sent, sb.results_checked, cycle_count);
        $display("results by kind: realtime %0d, test %0d, dropped %0d, abandoned %0d",
            sb.kind_count[hsfd_pkg::KIND_REALTIME], sb.kind_count[hsfd_pkg::KIND_TEST],
            sb.kind_count[hsfd_pkg::KIND_DROPPED], sb.kind_count[hsfd_pkg::KIND_ABANDON]);
        if (sb.mismatches == 0) begin
            $display("health_sensor_frame_deframer regression: pass");
        end else begin
            $display("health_sensor_frame_deframer regression: fail");
        end
        $finish;
    end

endmodule
